>>> hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Request commands.
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-cycle control broadcast to every cell in the row.
  typedef struct packed {
    logic enq;  // insert the new entry this cycle
    logic deq;  // remove the head this cycle
  } cell_ctl_t;

endpackage

>>> hw/rtl/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry and trades it with neighbors.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int PRIORITY_BITS = 8,
  parameter int PAYLOAD_BITS  = 32
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic                     occupied,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  input  logic [PAYLOAD_BITS-1:0]  new_payload,
  input  logic                     prev_keep,
  input  logic [PRIORITY_BITS-1:0] prev_prio,
  input  logic [PAYLOAD_BITS-1:0]  prev_payload,
  input  logic [PRIORITY_BITS-1:0] next_prio,
  input  logic [PAYLOAD_BITS-1:0]  next_payload,
  output logic                     keep,
  output logic [PRIORITY_BITS-1:0] prio,
  output logic [PAYLOAD_BITS-1:0]  payload
);

  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;
  logic [PAYLOAD_BITS-1:0]  payload_r, payload_nxt;

  // A stored entry of greater or equal priority stays ahead of a new one.
  assign keep = occupied && (prio_r >= new_prio);

  always_comb begin
    prio_nxt    = prio_r;
    payload_nxt = payload_r;
    if (ctl.enq && !keep) begin
      // The first cell that does not keep takes the new entry; later cells
      // shift down by one.
      if (prev_keep) begin
        prio_nxt    = new_prio;
        payload_nxt = new_payload;
      end else begin
        prio_nxt    = prev_prio;
        payload_nxt = prev_payload;
      end
    end else if (ctl.deq) begin
      prio_nxt    = next_prio;
      payload_nxt = next_payload;
    end
  end

  always_ff @(posedge clk) begin
    prio_r    <= prio_nxt;
    payload_r <= payload_nxt;
  end

  assign prio    = prio_r;
  assign payload = payload_r;

endmodule

>>> hw/rtl/spq_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_out_buf
// Output register with a skid slot, so a stalled result does not block input.
// ----------------------------------------------------------------------------
module spq_out_buf #(
  parameter int W = 48
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         can_push,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         main_v_r, main_v_nxt;
  logic         skid_v_r, skid_v_nxt;
  logic [W-1:0] main_d_r, main_d_nxt;
  logic [W-1:0] skid_d_r, skid_d_nxt;
  logic         pop;

  assign pop      = main_v_r && out_ready;
  assign can_push = !skid_v_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_d_nxt = main_d_r;
    skid_d_nxt = skid_d_r;
    if (push) begin
      // Skid is empty here, so the new result goes to the front if it frees.
      if (!main_v_r || pop) begin
        main_v_nxt = 1'b1;
        main_d_nxt = push_data;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = push_data;
      end
    end else if (pop) begin
      main_v_nxt = skid_v_r;
      main_d_nxt = skid_d_r;
      skid_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_d_r <= main_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_valid = main_v_r;
  assign out_data  = main_d_r;

endmodule

>>> hw/rtl/stable_sorted_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_core
// Bounded priority queue kept sorted in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_tvalid/in_tready/in_tdata. Each one is an enqueue
//   (priority and payload) or a dequeue of the head. Entries sit in a row of
//   cells in descending priority, ties in arrival order; an enqueue drops in
//   behind every entry of greater or equal priority, a dequeue shifts the row
//   up toward cell 0.
//   Every request gives exactly one result on out_tvalid/out_tready/out_tdata:
//   status, dequeued priority and payload (zero unless a dequeue succeeded),
//   the empty flag and the entry count after the request.
//   Throughput: one request per cycle while in_tready is high. All cells
//   compare and move in the same cycle as the request is accepted, so the cell
//   row update is the only work. The result is registered in the output buffer.
//   A stalled receiver is absorbed by an output register plus a skid slot;
//   in_tready drops only once both hold undelivered results.
//   Reset (rst_n low, synchronous) empties the queue and the result buffer.
//   The cell contents are not cleared; only the occupied cells are read.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PRIORITY_BITS = 8,
  parameter int PAYLOAD_BITS  = 32,
  localparam int CW   = $clog2(QUEUE_DEPTH + 1),
  localparam int IN_W = ((1 + PRIORITY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 + PRIORITY_BITS + PAYLOAD_BITS + 1 + CW + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  // From bit 0: command, priority_req, payload, zero pad.
  input  logic [IN_W-1:0] in_tdata,
  output logic            out_tvalid,
  input  logic            out_tready,
  // From bit 0: status, out_priority, out_payload, is_empty, entry_count, pad.
  output logic [OUT_W-1:0] out_tdata
);

  localparam int RES_W = 2 + PRIORITY_BITS + PAYLOAD_BITS + 1 + CW;

  logic                     in_cmd;
  logic [PRIORITY_BITS-1:0] in_prio;
  logic [PAYLOAD_BITS-1:0]  in_payload;
  logic                     accept;
  logic                     is_full, is_empty_now;

  logic [CW-1:0] count_r, count_nxt;
  cell_ctl_t     ctl;
  status_t       status;

  logic [PRIORITY_BITS-1:0] cell_prio    [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0]  cell_payload [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   cell_keep;

  logic [PRIORITY_BITS-1:0] res_prio;
  logic [PAYLOAD_BITS-1:0]  res_payload;
  logic [RES_W-1:0]         res;

  assign in_cmd     = in_tdata[0];
  assign in_prio    = in_tdata[PRIORITY_BITS:1];
  assign in_payload = in_tdata[PRIORITY_BITS+PAYLOAD_BITS:PRIORITY_BITS+1];

  assign accept       = in_tvalid && in_tready;
  assign is_full      = (count_r == CW'(QUEUE_DEPTH));
  assign is_empty_now = (count_r == '0);

  always_comb begin
    ctl       = '0;
    status    = ST_DONE;
    count_nxt = count_r;
    if (accept) begin
      if (in_cmd == CMD_ENQ) begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          ctl.enq   = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end else begin
        if (is_empty_now) begin
          status = ST_EMPTY;
        end else begin
          ctl.deq   = 1'b1;
          count_nxt = count_r - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                     occ;
    logic                     prev_keep;
    logic [PRIORITY_BITS-1:0] prev_prio, next_prio;
    logic [PAYLOAD_BITS-1:0]  prev_payload, next_payload;

    assign occ = (CW'(i) < count_r);

    if (i == 0) begin : g_first
      assign prev_keep    = 1'b1;
      assign prev_prio    = in_prio;
      assign prev_payload = in_payload;
    end else begin : g_mid
      assign prev_keep    = cell_keep[i-1];
      assign prev_prio    = cell_prio[i-1];
      assign prev_payload = cell_payload[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_prio    = cell_prio[i];
      assign next_payload = cell_payload[i];
    end else begin : g_inner
      assign next_prio    = cell_prio[i+1];
      assign next_payload = cell_payload[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occ),
      .new_prio    (in_prio),
      .new_payload (in_payload),
      .prev_keep   (prev_keep),
      .prev_prio   (prev_prio),
      .prev_payload(prev_payload),
      .next_prio   (next_prio),
      .next_payload(next_payload),
      .keep        (cell_keep[i]),
      .prio        (cell_prio[i]),
      .payload     (cell_payload[i])
    );
  end

  assign res_prio    = ctl.deq ? cell_prio[0] : '0;
  assign res_payload = ctl.deq ? cell_payload[0] : '0;
  assign res = {count_nxt, (count_nxt == '0), res_payload, res_prio, status};

  spq_out_buf #(
    .W(OUT_W)
  ) u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_data(OUT_W'(res)),
    .can_push (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_tdata)
  );

endmodule

>>> hw/rtl/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the result stream of the priority queue.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PRIORITY_BITS = 8,
  parameter int PAYLOAD_BITS  = 32,
  localparam int CW    = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_W = ((2 + PRIORITY_BITS + PAYLOAD_BITS + 1 + CW + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  localparam int EMPTY_BIT = 2 + PRIORITY_BITS + PAYLOAD_BITS;

  logic [1:0]                status_f;
  logic [PRIORITY_BITS-1:0]  prio_f;
  logic [PAYLOAD_BITS-1:0]   payload_f;
  logic                      empty_f;
  logic [CW-1:0]             count_f;

  assign status_f  = out_tdata[1:0];
  assign prio_f    = out_tdata[PRIORITY_BITS+1:2];
  assign payload_f = out_tdata[PRIORITY_BITS+PAYLOAD_BITS+1:PRIORITY_BITS+2];
  assign empty_f   = out_tdata[EMPTY_BIT];
  assign count_f   = out_tdata[EMPTY_BIT+CW:EMPTY_BIT+1];

  // The empty flag must agree with the reported count.
  a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (empty_f == (count_f == '0)))
    else $error("empty flag disagrees with entry count");

  // The count never exceeds the capacity of the cell row.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (count_f <= CW'(QUEUE_DEPTH)))
    else $error("entry count above queue depth");

  // Any result other than done carries no dequeued entry.
  a_reject_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (status_f != ST_DONE)) |-> ((prio_f == '0) && (payload_f == '0)))
    else $error("rejected request carries data");

  // An empty-queue dequeue reports an empty queue; a full reject reports full.
  a_status_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((status_f == ST_DONE) ||
                    ((status_f == ST_EMPTY) && empty_f) ||
                    ((status_f == ST_FULL) && (count_f == CW'(QUEUE_DEPTH)))))
    else $error("bad status code or status inconsistent with count");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

endmodule

bind stable_sorted_priority_queue_core spq_checker #(
  .QUEUE_DEPTH  (QUEUE_DEPTH),
  .PRIORITY_BITS(PRIORITY_BITS),
  .PAYLOAD_BITS (PAYLOAD_BITS)
) u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the stable sorted priority queue against a software copy of its row.
// A tracker class keeps its own sorted list of entries and predicts the result
// of every accepted request. Each result the block returns is compared field by
// field with the oldest prediction. Stimulus starts with a short directed run
// over empty, full, extreme and tied priorities. After that come random phases
// that lean toward enqueues or dequeues, so the queue fills and drains again
// and again. Both handshakes see random gaps.
// ----------------------------------------------------------------------------
module testbench;
  import spq_pkg::*;

  localparam int QUEUE_SLOTS = 16;
  localparam int IN_W        = 48;
  localparam int OUT_W       = 48;
  localparam int RANDOM_REQS = 930;

  typedef struct {
    logic [1:0]  status;
    logic [7:0]  prio;
    logic [31:0] data;
    logic        empty;
    logic [4:0]  count;
  } queue_result_t;

  class queue_tracker;
    logic [7:0]    prio_row [QUEUE_SLOTS];
    logic [31:0]   data_row [QUEUE_SLOTS];
    int            held = 0;
    queue_result_t awaited [$];
    int            errors = 0;

    // Applies one accepted request to the local row and queues its result.
    function void note_request(logic cmd, logic [7:0] prio, logic [31:0] data);
      queue_result_t r;
      int            pos;
      r.status = ST_DONE;
      r.prio   = '0;
      r.data   = '0;
      if (cmd == CMD_ENQ) begin
        if (held == QUEUE_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          // The new entry goes behind every entry of greater or equal priority.
          while (pos < held && prio_row[pos] >= prio) pos++;
          for (int i = held; i > pos; i--) begin
            prio_row[i] = prio_row[i-1];
            data_row[i] = data_row[i-1];
          end
          prio_row[pos] = prio;
          data_row[pos] = data;
          held++;
        end
      end else begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.prio = prio_row[0];
          r.data = data_row[0];
          for (int i = 1; i < held; i++) begin
            prio_row[i-1] = prio_row[i];
            data_row[i-1] = data_row[i];
          end
          held--;
        end
      end
      r.empty = (held == 0);
      r.count = 5'(held);
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] word);
      queue_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result %h arrived with no request waiting", $time, word);
        errors++;
      end else begin
        want = awaited.pop_front();
        compare_field("status", 32'(want.status), 32'(word[1:0]));
        compare_field("out_priority", 32'(want.prio), 32'(word[9:2]));
        compare_field("out_payload", want.data, word[41:10]);
        compare_field("is_empty", 32'(want.empty), 32'(word[42]));
        compare_field("entry_count", 32'(want.count), 32'(word[47:43]));
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  queue_tracker tracker = new();
  logic         steady = 1'b0;  // no idling on either side while set

  stable_sorted_priority_queue_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(10, 40);
    end
  endfunction

  // Presents one request from a falling edge and holds it until accepted.
  task automatic send_request(logic cmd, logic [7:0] prio, logic [31:0] data);
    int gap;
    gap = (!steady && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {7'b0, data, prio, cmd};
    do @(posedge clk); while (!in_tready);
    tracker.note_request(cmd, prio, data);
    @(negedge clk);
  endtask

  // Receiver readiness with random stalls.
  initial begin
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else begin
        out_tready = 1'b1;
        if (!steady && $urandom_range(0, 5) == 0) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
  end

  initial begin
    int          enq_pct;
    logic        cmd;
    logic [7:0]  prio;
    int          pick;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part: empty dequeue, extremes, ties, filling up, full rejection.
    send_request(CMD_DEQ, 8'h00, 32'h0);
    send_request(CMD_ENQ, 8'hFF, 32'hFFFF_FFFF);
    send_request(CMD_ENQ, 8'h00, 32'h0000_0000);
    send_request(CMD_ENQ, 8'h80, 32'h0000_0001);
    send_request(CMD_ENQ, 8'h80, 32'h0000_0002);
    send_request(CMD_ENQ, 8'h80, 32'h0000_0003);
    for (int i = 0; i < 10; i++) begin
      send_request(CMD_ENQ, 8'($urandom_range(0, 255)), $urandom);
    end
    send_request(CMD_ENQ, 8'h80, 32'h0000_0004);
    send_request(CMD_ENQ, 8'h55, 32'hA5A5_A5A5);
    repeat (3) send_request(CMD_DEQ, 8'hFF, 32'hFFFF_FFFF);

    // Random phases that push the queue toward full, toward empty, or hold it.
    enq_pct = 50;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 62 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 85;
          1: enq_pct = 50;
          default: enq_pct = 15;
        endcase
        steady = ($urandom_range(0, 3) == 0);
      end
      cmd  = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        prio = 8'($urandom_range(0, 255));
      end else if (pick < 8) begin
        // A narrow band gives many ties, which exercises arrival order.
        prio = 8'($urandom_range(126, 129));
      end else begin
        prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      send_request(cmd, prio, $urandom);
    end
    in_tvalid = 1'b0;
    steady    = 1'b1;

    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
